FILE: sv/pli_pkg.sv
// ---------------------------------------------------------------------------
// pli_pkg: shared types and constants for the interpolation table
// Opcodes, table sizing and the control/status bundles between the
// sequencer and the point store.
// ---------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int XW         = 32;
  localparam int DIV_STEPS  = XW;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef struct packed {
    logic             clear;
    logic             append;
    logic [XW-1:0]    wr_x;
    logic [XW-1:0]    wr_y;
    logic [IDX_W-1:0] rd_addr;
  } tbl_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [XW-1:0]    first_x;
    logic [XW-1:0]    last_x;
    logic [XW-1:0]    last_y;
  } tbl_stat_t;

endpackage

`default_nettype wire

FILE: sv/pli_table.sv
// ---------------------------------------------------------------------------
// pli_table: point store
// Abscissa and ordinate memories with one write and one registered read
// port, plus the point count and the first/last point kept in flops.
// ---------------------------------------------------------------------------
`default_nettype none

module pli_table import pli_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tbl_cmd_t  cmd,
  output logic [XW-1:0]  rd_x,
  output logic [XW-1:0]  rd_y,
  output tbl_stat_t      stat
);

  logic [XW-1:0] x_mem [MAX_POINTS];
  logic [XW-1:0] y_mem [MAX_POINTS];

  logic [CNT_W-1:0] count;
  logic [XW-1:0]    first_x;
  logic [XW-1:0]    last_x;
  logic [XW-1:0]    last_y;
  logic             wr_ok;

  // drop appends to a full table or that do not ascend
  assign wr_ok = cmd.append && (count < CNT_W'(MAX_POINTS)) &&
                 ((count == '0) || ($signed(cmd.wr_x) > $signed(last_x)));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (wr_ok) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      x_mem[count[IDX_W-1:0]] <= cmd.wr_x;
      y_mem[count[IDX_W-1:0]] <= cmd.wr_y;
      last_x <= cmd.wr_x;
      last_y <= cmd.wr_y;
      if (count == '0) begin
        first_x <= cmd.wr_x;
      end
    end
    rd_x <= x_mem[cmd.rd_addr];
    rd_y <= y_mem[cmd.rd_addr];
  end

  assign stat.count   = count;
  assign stat.first_x = first_x;
  assign stat.last_x  = last_x;
  assign stat.last_y  = last_y;

endmodule

`default_nettype wire

FILE: sv/pli_div.sv
// ---------------------------------------------------------------------------
// pli_div: serial restoring divider
// Divides a 64-bit dividend by a 32-bit divisor, one quotient bit per
// cycle; the upper dividend half must be below the divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module pli_div import pli_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [2*XW-1:0]   dividend,
  input  wire logic [XW-1:0]     divisor,
  output logic                   done,
  output logic [XW-1:0]          quotient
);

  logic [XW-1:0]     rem;
  logic [XW-1:0]     shq;
  logic [XW-1:0]     den;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [XW:0]       trial;

  assign trial    = {rem, shq[XW-1]} - {1'b0, den};
  assign quotient = shq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == DCNT_W'(DIV_STEPS - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == DCNT_W'(DIV_STEPS - 1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[2*XW-1:XW];
      shq <= dividend[XW-1:0];
      den <= divisor;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + DCNT_W'(1);
      if (!trial[XW]) begin
        rem <= trial[XW-1:0];
        shq <= {shq[XW-2:0], 1'b1};
      end else begin
        rem <= {rem[XW-2:0], shq[XW-1]};
        shq <= {shq[XW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/piecewise_linear_interpolator.sv
// ---------------------------------------------------------------------------
// piecewise_linear_interpolator: Q16.16 piecewise-linear lookup table
// Points are appended in ascending x; a query is placed by binary search
// and interpolated toward the next point with one serial division.
// ---------------------------------------------------------------------------
//
//  channel   dir  payload                               words
//  s_axis    in   tdata {y, x}, tuser op               clear/append/eval
//  m_axis    out  tdata value, tuser out_of_range      one per eval
//
//  Clear and append words are taken without leaving the idle state. An
//  eval word runs a range check, a search and a compare state per search
//  step for the registered table read plus one closing search step, two
//  ordinate reads, the multiply states MUL and MUL2, the divider start and
//  a wait on the serial divider, then the result state; no new word is
//  taken until the sequencer is back in the idle state.
//  Out-of-range and last-point queries skip straight to the result state.
//  rst is synchronous; it empties the table and drops any pending result.
//  A finished result waits in the output register while m_axis is stalled;
//  the next word is accepted meanwhile, but its result holds until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator import pli_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [63:0]   s_axis_tdata,   // [31:0] x, [63:32] y
  input  wire logic [1:0]    s_axis_tuser,   // [1:0] op
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [31:0] value
  output logic [0:0]         m_axis_tuser    // [0] out_of_range
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_SEARCH = 4'd2;
  localparam logic [3:0] ST_CMP    = 4'd3;
  localparam logic [3:0] ST_RD_LO  = 4'd4;
  localparam logic [3:0] ST_RD_HI  = 4'd5;
  localparam logic [3:0] ST_MUL    = 4'd6;
  localparam logic [3:0] ST_MUL2   = 4'd7;
  localparam logic [3:0] ST_DIVS   = 4'd8;
  localparam logic [3:0] ST_DIVW   = 4'd9;
  localparam logic [3:0] ST_RESULT = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  tbl_cmd_t  cmd;
  tbl_stat_t stat;
  logic [XW-1:0] rd_x;
  logic [XW-1:0] rd_y;

  logic [XW-1:0]    q;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] span;
  logic [IDX_W-1:0] mid_c;
  logic [XW-1:0]    xlo;
  logic [XW-1:0]    xhi;
  logic [XW-1:0]    ylo;
  logic [XW-1:0]    dx;
  logic [XW-1:0]    den;
  logic [XW:0]      dy_c;
  logic [XW:0]      mag;
  logic             neg;
  logic [2*XW-1:0]  prod_lo;
  logic [2*XW-1:0]  prod;
  logic [CNT_W-1:0] n_minus_1;

  logic          div_start;
  logic          div_done;
  logic [XW-1:0] div_quo;

  logic [XW-1:0] res_value;
  logic          res_oor;
  logic          in_accept;
  logic          out_load;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_load  = (state == ST_RESULT) && (!m_axis_tvalid || m_axis_tready);
  assign div_start = (state == ST_DIVS);

  assign span      = hi - lo;
  assign mid_c     = lo + (span >> 1);
  assign n_minus_1 = stat.count - CNT_W'(1);
  assign dy_c      = {rd_y[XW-1], rd_y} - {ylo[XW-1], ylo};

  // table commands: write on accepted append/clear words, address the search
  always_comb begin
    cmd.clear   = in_accept && (s_axis_tuser == OP_CLEAR);
    cmd.append  = in_accept && (s_axis_tuser == OP_APPEND);
    cmd.wr_x    = s_axis_tdata[31:0];
    cmd.wr_y    = s_axis_tdata[63:32];
    cmd.rd_addr = hi;
    if (state == ST_SEARCH) begin
      cmd.rd_addr = (span > IDX_W'(1)) ? mid_c : lo;
    end
  end

  pli_table u_table (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .rd_x (rd_x),
    .rd_y (rd_y),
    .stat (stat)
  );

  pli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && (s_axis_tuser == OP_EVAL)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ((stat.count < CNT_W'(2)) || ($signed(q) < $signed(stat.first_x)) ||
            ($signed(q) >= $signed(stat.last_x))) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: state_next = (span > IDX_W'(1)) ? ST_CMP : ST_RD_LO;
      ST_CMP:    state_next = ST_SEARCH;
      ST_RD_LO:  state_next = ST_RD_HI;
      ST_RD_HI:  state_next = ST_MUL;
      ST_MUL:    state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_DIVS;
      ST_DIVS:   state_next = ST_DIVW;
      ST_DIVW: begin
        if (div_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        q <= s_axis_tdata[31:0];
      end
      ST_CHECK: begin
        // outside the span or too few points: flag; last x: return last y
        if ((stat.count < CNT_W'(2)) || ($signed(q) < $signed(stat.first_x)) ||
            ($signed(q) > $signed(stat.last_x))) begin
          res_value <= '0;
          res_oor   <= 1'b1;
        end else begin
          res_value <= stat.last_y;
          res_oor   <= 1'b0;
        end
        lo  <= '0;
        hi  <= n_minus_1[IDX_W-1:0];
        xlo <= stat.first_x;
        xhi <= stat.last_x;
      end
      ST_SEARCH: begin
        mid <= mid_c;
      end
      ST_CMP: begin
        // keep lo on the last point not above the query
        if ($signed(rd_x) <= $signed(q)) begin
          lo  <= mid;
          xlo <= rd_x;
        end else begin
          hi  <= mid;
          xhi <= rd_x;
        end
      end
      ST_RD_LO: begin
        ylo <= rd_y;
        dx  <= q - xlo;
        den <= xhi - xlo;
      end
      ST_RD_HI: begin
        neg <= dy_c[XW];
        mag <= dy_c[XW] ? (~dy_c + (XW+1)'(1)) : dy_c;
      end
      ST_MUL: begin
        prod_lo <= dx * mag[XW-1:0];
      end
      ST_MUL2: begin
        // magnitude bit 32 is never set: the ordinate step is at most 2^32 - 1
        prod <= prod_lo + (mag[XW] ? {dx, {XW{1'b0}}} : {2*XW{1'b0}});
      end
      ST_DIVW: begin
        if (div_done) begin
          res_value <= neg ? (ylo - div_quo) : (ylo + div_quo);
          res_oor   <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata    <= res_value;
      m_axis_tuser[0] <= res_oor;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(MAX_POINTS))
    else $error("point count above table size");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (lo < hi))
    else $error("search bounds crossed");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVW))
    else $error("divider finished outside its wait state");

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DIVW) && div_done) |-> ({1'b0, div_quo} <= mag))
    else $error("quotient exceeds ordinate step");

  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_RESULT))
    else $error("result word raised outside result state");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for piecewise_linear_interpolator
// Streams clear, append and lookup words into the table, predicts every
// lookup from a private copy of the point table and compares each result
// word with the oldest prediction still due.
// ---------------------------------------------------------------------------

import pli_pkg::*;

typedef struct {
  bit signed [31:0] query;
  bit        [31:0] value;
  bit               oor;
} lookup_t;

class interp_scoreboard;
  bit signed [31:0] pt_x [MAX_POINTS];
  bit signed [31:0] pt_y [MAX_POINTS];
  int unsigned      n_points;
  lookup_t          due_results[$];
  int               n_err;

  function void flag(string msg);
    n_err++;
    if (n_err <= 10) $display("%0t ERROR %s", $time, msg);
  endfunction

  // Last point at or below q, then one step toward the next point.
  function lookup_t interpolate(bit signed [31:0] q);
    lookup_t     r;
    int unsigned lo, hi, mid;
    longint      dx, dy, den, mag, res;
    bit [63:0]   prod, quo;
    r.query = q;
    r.value = '0;
    r.oor   = 1'b1;
    if (n_points < 2) return r;
    if (q < pt_x[0] || q > pt_x[n_points-1]) return r;
    r.oor = 1'b0;
    if (q == pt_x[n_points-1]) begin
      r.value = pt_y[n_points-1];
      return r;
    end
    lo = 0;
    hi = n_points - 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (pt_x[mid] <= q) lo = mid;
      else hi = mid;
    end
    dx   = longint'(q) - longint'(pt_x[lo]);
    dy   = longint'(pt_y[hi]) - longint'(pt_y[lo]);
    den  = longint'(pt_x[hi]) - longint'(pt_x[lo]);
    mag  = (dy < 0) ? -dy : dy;
    prod = 64'(dx) * 64'(mag);
    quo  = prod / 64'(den);
    res  = (dy < 0) ? longint'(pt_y[lo]) - longint'(quo)
                    : longint'(pt_y[lo]) + longint'(quo);
    r.value = 32'(res);
    return r;
  endfunction

  function void note_word(logic [1:0] op, bit signed [31:0] x, bit signed [31:0] y);
    case (op)
      OP_CLEAR: n_points = 0;
      OP_APPEND: begin
        if (n_points < MAX_POINTS && (n_points == 0 || x > pt_x[n_points-1])) begin
          pt_x[n_points] = x;
          pt_y[n_points] = y;
          n_points++;
        end
      end
      OP_EVAL: due_results.insert(due_results.size(), interpolate(x));
      default: ;
    endcase
  endfunction

  function void check_result(bit [31:0] value, bit oor);
    lookup_t e;
    if (due_results.size() == 0) begin
      flag($sformatf("result with nothing due: value %h oor %0b", value, oor));
      return;
    end
    e = due_results.pop_front();
    if (value !== e.value)
      flag($sformatf("x=%h value exp %h got %h", e.query, e.value, value));
    if (oor !== e.oor)
      flag($sformatf("x=%h out_of_range exp %0b got %0b", e.query, e.oor, oor));
  endfunction

  function int pending();
    return due_results.size();
  endfunction
endclass

module tb;

  localparam int          N_ITEMS     = 1050;
  localparam int          STALL_LIMIT = 4000;  // cycles with no word moving
  localparam int          HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int          DRAIN_CYCLES = 120;  // beyond the slowest lookup
  localparam logic [31:0] S32_MIN     = 32'h8000_0000;
  localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
  localparam longint      L_MIN       = -64'sd2147483648;
  localparam longint      L_MAX       = 64'sd2147483647;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [31:0] x, [63:32] y
  logic [1:0]  s_axis_tuser = OP_NOP; // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] value
  logic [0:0]  m_axis_tuser;        // [0] out_of_range

  interp_scoreboard sb = new;

  // Stimulus-side view of the table: the abscissas the block should hold,
  // used only to aim queries and to keep appends ascending.
  longint gen_x[$];
  longint last_y;
  int     n_sent;
  bit     no_gaps;   // both sides run without idling while set
  bit     hold_req;  // ask the result side for one long hold-off
  int     quiet_cycles;

  piecewise_linear_interpolator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check results before noting new words: a result can never belong to a
  // word taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser[0]);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_word(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("piecewise_linear_interpolator: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request so the
  // output register fills and the block backs up onto its input.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= 15);
      end
    end
  end

  // Offer one word and hold it until taken; tvalid stays high into the next
  // word unless an idle gap is drawn.
  task automatic send_word(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y);
    int gap;
    gap = 0;
    if (!no_gaps)
      while ($urandom_range(99) < 15) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op != OP_NOP) n_sent++;
    // track what the table should now hold
    if (op == OP_CLEAR) begin
      gen_x.delete();
    end else if (op == OP_APPEND && gen_x.size() < MAX_POINTS) begin
      if (gen_x.size() == 0 || longint'($signed(x)) > gen_x[$])
        gen_x.insert(gen_x.size(), longint'($signed(x)));
    end
  endtask

  // Append n points with steps up to scale; a few are pushed out of order
  // on purpose and get dropped.
  task automatic append_run(input int n, input longint scale);
    longint cur, room, step_max, y;
    for (int i = 0; i < n; i++) begin
      if (gen_x.size() == 0) begin
        cur = (n > 16) ? L_MIN + longint'($urandom_range(32'h3FFF_FFFF))
                       : longint'($signed($urandom));
      end else if ($urandom_range(99) < 6) begin
        cur = gen_x[$] - longint'($urandom_range(3));  // equal or behind: dropped
      end else begin
        room     = L_MAX - gen_x[$];
        step_max = room / (n - i);
        if (step_max > scale) step_max = scale;
        if (step_max < 1) step_max = 1;
        cur = gen_x[$] + 1 + longint'($urandom) % step_max;
      end
      if ($urandom_range(1))
        y = longint'($signed($urandom));
      else
        y = last_y + longint'($urandom_range(2000)) - 1000;
      last_y = longint'($signed(32'(y)));
      send_word(OP_APPEND, 32'(cur), 32'(y));
    end
  endtask

  // Aim mostly inside the span, with exact hits and misses on both ends.
  function automatic logic [31:0] pick_query();
    int     n, i, r;
    longint q, width;
    n = gen_x.size();
    r = $urandom_range(99);
    if (n < 2 || r >= 92) return $urandom;
    if (r < 60) begin
      i = $urandom_range(n - 2, 0);
      width = gen_x[i+1] - gen_x[i];
      q = gen_x[i] + longint'($urandom) % width;
    end else if (r < 75) begin
      q = gen_x[$urandom_range(n - 1, 0)];
    end else if (r < 84) begin
      q = gen_x[0] - 1 - longint'($urandom_range(1000));
      if (q < L_MIN) q = L_MIN;
    end else begin
      q = gen_x[$] + 1 + longint'($urandom_range(1000));
      if (q > L_MAX) q = L_MAX;
    end
    return 32'(q);
  endfunction

  task automatic lookups(input int n);
    repeat (n) send_word(OP_EVAL, pick_query(), $urandom);
  endtask

  initial begin : stimulus
    bit     filled, held;
    int     npts, r;
    longint scale;
    filled = 0;
    held   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty and single-point tables, both ends of the span,
    // dropped appends, the unused op, a flat segment and full-range values.
    send_word(OP_EVAL,   32'd0,   32'd0);           // no points
    send_word(OP_APPEND, S32_MIN, S32_MAX);
    send_word(OP_EVAL,   S32_MIN, 32'd0);           // one point only
    send_word(OP_APPEND, 32'd0,   S32_MIN);
    send_word(OP_APPEND, 32'd0,   32'd5);           // equal x: dropped
    send_word(OP_APPEND, -32'sd5, 32'd7);           // smaller x: dropped
    send_word(OP_EVAL,   S32_MIN, 32'hFFFF_FFFF);   // exactly first point
    send_word(OP_EVAL,   -32'sd1, 32'd0);           // widest falling segment
    send_word(OP_EVAL,   32'd0,   32'd0);           // exactly last point
    send_word(OP_EVAL,   32'd1,   32'd0);           // above last point
    send_word(OP_APPEND, S32_MAX, S32_MAX);
    send_word(OP_EVAL,   32'h7FFF_FFFE, 32'd0);
    send_word(OP_EVAL,   S32_MAX, 32'd0);           // last point at top of range
    send_word(OP_NOP,    32'h1234_5678, 32'h9ABC_DEF0);
    send_word(OP_EVAL,   32'h4000_0000, 32'd0);
    send_word(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_EVAL,   32'd0,   32'd0);           // emptied table
    send_word(OP_APPEND, 32'd100, -32'sd7);
    send_word(OP_APPEND, 32'd200, -32'sd7);         // flat segment
    send_word(OP_EVAL,   32'd150, 32'd0);
    send_word(OP_EVAL,   32'd99,  32'd0);           // below first point
    send_word(OP_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_EVAL,   32'd200, 32'hFFFF_FFFF);

    // Random: mostly clear / append run / lookup bursts, some noise.
    while (n_sent < N_ITEMS) begin
      no_gaps = (n_sent >= 350 && n_sent < 550);
      r = $urandom_range(99);
      if (!filled && n_sent > 200) begin
        // fill the table, then push appends that must be dropped
        send_word(OP_CLEAR, $urandom, $urandom);
        append_run(MAX_POINTS + 4, 64'd1 << 20);
        lookups(20);
        filled = 1;
      end else if (r < 82) begin
        if ($urandom_range(3) != 0) send_word(OP_CLEAR, $urandom, $urandom);
        r = $urandom_range(99);
        npts = (r < 70) ? $urandom_range(8, 2) :
               (r < 95) ? $urandom_range(40, 9) : $urandom_range(120, 41);
        case ($urandom_range(4))
          0: scale = 16;
          1: scale = 64'd1 << 12;
          2: scale = 64'd1 << 20;
          3: scale = 64'd1 << 28;
          default: scale = 64'hFFFF_FFFF;
        endcase
        append_run(npts, scale);
        if (!held && n_sent > 700) begin
          // keep offering lookups while the result side holds off
          hold_req = 1'b1;
          held = 1;
          lookups(24);
        end else begin
          lookups($urandom_range(16, 3));
        end
      end else begin
        repeat ($urandom_range(6, 1)) begin
          r = $urandom_range(3);
          send_word(r[1:0], (r == OP_EVAL) ? pick_query() : $urandom, $urandom);
        end
      end
    end
    // drop tvalid at the edge that took the last word
    no_gaps = 0;
    s_axis_tvalid <= 1'b0;

    // Drain: every lookup answered, then watch for stray results.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_err == 0 && sb.pending() == 0)
      $display("piecewise_linear_interpolator: match");
    else
      $display("piecewise_linear_interpolator: mismatch");
    $finish;
  end

endmodule
